/* sv/mhi_pkg.sv */
// Package for the min-heap insert unit: request and result item types,
// status and request codes, and the sequencer state type. No dependencies.
`default_nettype none

package mhi_pkg;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } mhi_status_t;

  // Request item
  typedef struct packed {
    logic               req_type;
    logic signed [31:0] key;
    logic [6:0]         entry_index;
  } mhi_req_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]         heap_size;
    logic [1:0]         status;
  } mhi_rsp_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIFT,
    ST_CMP,
    ST_RD_DATA,
    ST_RESULT
  } mhi_state_t;

endpackage

`default_nettype wire

/* sv/mhi_ram.sv */
// Key store for the min-heap insert unit: one write port, one read port,
// read data registered. No package dependencies.
`default_nettype none

module mhi_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* sv/min_heap_insert_unit.sv */
// Binary min-heap with insert (sift-up) and level-order read-back. An insert
// starts the key at the next free slot and walks it toward the root, one
// level at a time through the single key memory: the sift state reads the
// parent, the compare state compares and moves the parent down. A read
// fetches its entry and captures it in the read-data state; a full-heap
// insert or an out-of-range read goes straight to the result state. The
// block works on one item at a time; a finished result waits in the output
// register while the next item is taken. The result of an insert carries
// the new minimum, kept in a root register.
// Depends on mhi_pkg and mhi_ram.
`default_nettype none

module min_heap_insert_unit #(
  parameter int CAPACITY  = 128,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire mhi_pkg::mhi_req_t req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output mhi_pkg::mhi_rsp_t     rsp
);

  import mhi_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  mhi_state_t state, state_next;

  logic                        req_accept;
  logic                        rsp_free;
  logic [CW-1:0]               count;
  logic [AW-1:0]               pos;
  logic [AW-1:0]               parent;
  logic signed [KEY_WIDTH-1:0] ins_key;
  logic signed [KEY_WIDTH-1:0] root_key;
  logic signed [KEY_WIDTH-1:0] new_key;
  logic signed [KEY_WIDTH-1:0] rd_key;
  logic [CMPW-1:0]             idx_w;
  logic                        idx_ok;
  logic                        heap_full;
  logic                        key_less;
  logic signed [31:0]          res_value;
  logic [1:0]                  res_status;

  logic                 ram_wr_en;
  logic [AW-1:0]        ram_wr_addr;
  logic [KEY_WIDTH-1:0] ram_wr_data;
  logic                 ram_rd_en;
  logic [AW-1:0]        ram_rd_addr;
  logic [KEY_WIDTH-1:0] ram_rd_data;

  mhi_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(KEY_WIDTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Decode request and shared compare
  assign req_stall  = (state != ST_IDLE);
  assign req_accept = req_valid && (state == ST_IDLE);
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign new_key    = KEY_WIDTH'(req.key);
  assign rd_key     = ram_rd_data;
  assign idx_w      = CMPW'(req.entry_index);
  assign idx_ok     = idx_w < CMPW'(count);
  assign heap_full  = (count == CW'(CAPACITY));
  assign parent     = AW'((pos - AW'(1)) >> 1);
  assign key_less   = ins_key < rd_key;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_accept) begin
          if (req.req_type == REQ_READ) begin
            state_next = idx_ok ? ST_RD_DATA : ST_RESULT;
          end else begin
            state_next = heap_full ? ST_RESULT : ST_SIFT;
          end
        end
      end
      ST_SIFT: begin
        state_next = (pos == '0) ? ST_RESULT : ST_CMP;
      end
      ST_CMP: begin
        state_next = key_less ? ST_SIFT : ST_RESULT;
      end
      ST_RD_DATA: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory port control
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = pos;
    ram_wr_data = ins_key;
    ram_rd_en   = 1'b0;
    ram_rd_addr = parent;
    case (state)
      ST_IDLE: begin
        ram_rd_en   = req_accept && (req.req_type == REQ_READ) && idx_ok;
        ram_rd_addr = AW'(idx_w);
      end
      ST_SIFT: begin
        // at the root place the key, else fetch the parent
        ram_wr_en = (pos == '0);
        ram_rd_en = (pos != '0);
      end
      ST_CMP: begin
        // move the parent down, or settle the key here
        ram_wr_en   = 1'b1;
        ram_wr_data = key_less ? rd_key : ins_key;
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req_accept && (req.req_type == REQ_INSERT) && !heap_full) begin
      count <= count + CW'(1);
    end
  end

  // Working registers and result staging
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ins_key    <= new_key;
        pos        <= AW'(count);
        res_value  <= '0;
        res_status <= STATUS_OK;
        if (req.req_type == REQ_READ) begin
          if (!idx_ok) begin
            res_status <= STATUS_RANGE;
          end
        end else if (heap_full) begin
          res_status <= STATUS_FULL;
        end
      end
      ST_SIFT: begin
        if (pos == '0) begin
          root_key  <= ins_key;
          res_value <= 32'(ins_key);
        end
      end
      ST_CMP: begin
        if (key_less) begin
          pos <= parent;
        end else begin
          res_value <= 32'(root_key);
        end
      end
      ST_RD_DATA: begin
        res_value <= 32'(rd_key);
      end
      default: begin
        res_status <= res_status;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_RESULT && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && rsp_free) begin
      rsp.value     <= res_value;
      rsp.heap_size <= 8'(count);
      rsp.status    <= res_status;
    end
  end

endmodule

`default_nettype wire

/* tb/heap_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the min-heap insert unit: keeps its own copy of the heap,
// predicts each accepted request's result and compares it with the block's output.
// Depends on mhi_pkg.
module heap_result_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  mhi_pkg::mhi_req_t req,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  mhi_pkg::mhi_rsp_t rsp,
  output int                mismatch_count,
  output int                pending_items
);

  import mhi_pkg::*;

  localparam int HEAP_DEPTH = 128;
  localparam int REPORT_LIMIT = 10;

  logic signed [31:0] shadow_heap [HEAP_DEPTH];
  int unsigned        shadow_fill = 0;
  mhi_rsp_t           predicted_results [$];
  int                 fail_tally = 0;
  int                 waiting = 0;

  assign mismatch_count = fail_tally;
  assign pending_items  = waiting;

  // Apply one request to the shadow heap and return the result it should give.
  function automatic mhi_rsp_t apply_request(input mhi_req_t r);
    mhi_rsp_t           res;
    int unsigned        slot;
    int unsigned        parent;
    logic signed [31:0] held;
    bit                 climbing;
    res = '0;
    res.status = STATUS_OK;
    if (r.req_type == REQ_INSERT) begin
      if (shadow_fill >= HEAP_DEPTH) begin
        // drop the key, store untouched
        res.status = STATUS_FULL;
      end else begin
        slot = shadow_fill;
        shadow_heap[slot] = r.key;
        shadow_fill++;
        climbing = 1'b1;
        // sift up while strictly smaller than the parent; stop on an equal key
        while (climbing && slot > 0) begin
          parent = (slot - 1) / 2;
          if (shadow_heap[slot] < shadow_heap[parent]) begin
            held = shadow_heap[parent];
            shadow_heap[parent] = shadow_heap[slot];
            shadow_heap[slot] = held;
            slot = parent;
          end else begin
            climbing = 1'b0;
          end
        end
        res.value = shadow_heap[0];
      end
    end else if (r.entry_index >= shadow_fill) begin
      res.status = STATUS_RANGE;
    end else begin
      res.value = shadow_heap[r.entry_index];
    end
    res.heap_size = 8'(shadow_fill);
    return res;
  endfunction

  task automatic note_failure(input string what, input mhi_rsp_t want,
                              input mhi_rsp_t got);
    fail_tally++;
    if (fail_tally <= REPORT_LIMIT) begin
      $display("%0t: %s: expected value=%0d size=%0d status=%0d,",
               $realtime, what, want.value, want.heap_size, want.status,
               " got value=%0d size=%0d status=%0d",
               got.value, got.heap_size, got.status);
    end
  endtask

  // Predict on accepted requests, then match accepted results in order.
  always @(posedge clk) begin : watch
    mhi_rsp_t want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        predicted_results.push_back(apply_request(req));
      end
      if (rsp_valid && !rsp_stall) begin
        if (predicted_results.size() == 0) begin
          want = '0;
          note_failure("result with no request pending", want, rsp);
        end else begin
          want = predicted_results.pop_front();
          if (rsp.value !== want.value || rsp.heap_size !== want.heap_size ||
              rsp.status !== want.status) begin
            note_failure("result mismatch", want, rsp);
          end
        end
      end
      waiting = predicted_results.size();
    end
  end

endmodule

/* tb/tb_min_heap_insert_unit.sv */
`timescale 1ns / 1ps
// Top of the min-heap insert unit testbench: clock, reset, request stimulus
// and response stalls, verdict. Depends on mhi_pkg, the unit and heap_result_checker.
module tb_min_heap_insert_unit;
  import mhi_pkg::*;

  localparam int HEAP_DEPTH = 128;
  localparam int ITEMS_PER_PHASE = 138;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 40;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  mhi_req_t req;
  logic     rsp_valid;
  logic     rsp_stall;
  mhi_rsp_t rsp;
  int       mismatch_count;
  int       pending_items;

  int       idle_pct = 0;
  int       stall_pct = 0;
  int       inserted = 0;
  int       cycles = 0;

  min_heap_insert_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  heap_result_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req            (req),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp            (rsp),
    .mismatch_count (mismatch_count),
    .pending_items  (pending_items)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result channel at the current rate.
  always @(posedge clk) begin
    rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Bound the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Hand one item over: idle first at the current rate, then hold until accepted.
  task automatic send(input mhi_req_t item);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(negedge clk); while (req_stall);
    @(posedge clk);
    if (item.req_type == REQ_INSERT && inserted < HEAP_DEPTH) inserted++;
  endtask

  task automatic send_insert(input logic signed [31:0] k);
    mhi_req_t item;
    item = '0;
    item.req_type = REQ_INSERT;
    item.key = k;
    item.entry_index = 7'($urandom);
    send(item);
  endtask

  task automatic send_read(input logic [6:0] idx);
    mhi_req_t item;
    item = '0;
    item.req_type = REQ_READ;
    item.key = $urandom;
    item.entry_index = idx;
    send(item);
  endtask

  // Wait until every expected result has come back.
  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending_items != 0);
    @(posedge clk);
  endtask

  // Keys: mostly full range, some clustered to force equal keys, some extremes.
  function automatic logic signed [31:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(7);
    if (roll < 2) return 32'(int'($urandom_range(16)) - 8);
    if (roll == 2) return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
    return $urandom;
  endfunction

  task automatic random_item();
    bit do_insert;
    do_insert = (inserted < HEAP_DEPTH) ? ($urandom_range(99) < 55) : ($urandom_range(99) < 20);
    if (do_insert) begin
      send_insert(pick_key());
    end else if (inserted > 0 && $urandom_range(99) < 80) begin
      send_read(7'($urandom_range(inserted - 1)));
    end else begin
      send_read(7'($urandom));
    end
  endtask

  initial begin
    int idle_set [4];
    int stall_set [4];
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_stall = 1'b0;
    idle_set  = '{0, 50, 0, 16};
    stall_set = '{0, 0, 50, 16};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reads of an empty heap, extreme keys, equal keys, read-back of every filled slot.
    send_read(7'd0);
    send_read(7'd127);
    send_insert(32'sd0);
    send_insert(32'sh7fffffff);
    send_insert(32'sh80000000);
    send_insert(-32'sd1);
    send_insert(32'sd5);
    send_insert(32'sd5);
    send_insert(32'sh80000000);
    send_insert(32'sd1);
    for (int i = 0; i < 8; i++) send_read(7'(i));
    send_read(7'd8);
    send_read(7'd127);

    // Let everything come back before the random part.
    drain();

    // Random traffic over the idle and stall mixes; the heap fills and then overflows.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item();
      drain();
    end

    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_items == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
